/* design/lpfp_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package lpfp_pkg;

    localparam logic [1:0] KIND_NONE    = 2'd0;
    localparam logic [1:0] KIND_HEADER  = 2'd1;
    localparam logic [1:0] KIND_PAYLOAD = 2'd2;
    localparam logic [1:0] KIND_ERROR   = 2'd3;

    localparam logic [1:0] ERR_NONE       = 2'd0;
    localparam logic [1:0] ERR_BAD_MAGIC  = 2'd1;
    localparam logic [1:0] ERR_OVERSIZE   = 2'd2;
    localparam logic [1:0] ERR_SHORT_READ = 2'd3;

    localparam logic REG_MAGIC_WORD = 1'b0;
    localparam logic REG_LEN_LIMIT  = 1'b1;

    localparam logic [31:0] LEN_LIMIT_RESET = 32'd16777216;

    // Header byte positions: four magic bytes, one type byte, four length bytes.
    localparam logic [3:0] HDR_TYPE_IDX = 4'd4;
    localparam logic [3:0] HDR_LAST_IDX = 4'd8;

    typedef struct packed {
        logic [1:0]  result_kind;
        logic [7:0]  payload_byte;
        logic [7:0]  msg_type;
        logic [31:0] frame_length;
        logic [1:0]  error_code;
        logic        last_of_frame;
    } lpfp_result_t;

endpackage

`default_nettype wire

/* design/lpfp_core.sv */
`timescale 1ns / 1ps
`default_nettype none

module lpfp_core (
    input  wire                   aclk,
    input  wire                   aresetn,
    input  wire                   accept,
    input  wire  [7:0]            rx_byte,
    input  wire                   peer_closed,
    input  wire  [31:0]           magic_word,
    input  wire  [31:0]           len_limit,
    output lpfp_pkg::lpfp_result_t result
);
    import lpfp_pkg::*;

    logic        in_payload_reg;
    logic        in_payload_next;
    logic [3:0]  header_count_reg;
    logic [3:0]  header_count_next;
    logic [31:0] magic_seen_reg;
    logic [31:0] magic_seen_next;
    logic [7:0]  type_seen_reg;
    logic [7:0]  type_seen_next;
    logic [31:0] length_seen_reg;
    logic [31:0] length_seen_next;
    logic [31:0] payload_left_reg;
    logic [31:0] payload_left_next;

    logic [31:0] left_dec;
    logic [31:0] full_length;
    logic        clear_frame;

    assign left_dec    = payload_left_reg - 32'd1;
    assign full_length = {length_seen_reg[23:0], rx_byte};

    always_comb begin
        in_payload_next   = in_payload_reg;
        header_count_next = header_count_reg;
        magic_seen_next   = magic_seen_reg;
        type_seen_next    = type_seen_reg;
        length_seen_next  = length_seen_reg;
        payload_left_next = payload_left_reg;
        clear_frame       = 1'b0;
        result            = '0;

        if (peer_closed) begin
            result.result_kind = KIND_ERROR;
            result.error_code  = ERR_SHORT_READ;
            if (in_payload_reg) begin
                result.msg_type     = type_seen_reg;
                result.frame_length = length_seen_reg;
            end
            clear_frame = 1'b1;
        end else if (in_payload_reg) begin
            result.result_kind   = KIND_PAYLOAD;
            result.payload_byte  = rx_byte;
            result.msg_type      = type_seen_reg;
            result.frame_length  = length_seen_reg;
            result.last_of_frame = (left_dec == 32'd0);
            payload_left_next    = left_dec;
            clear_frame          = (left_dec == 32'd0);
        end else if (header_count_reg < HDR_TYPE_IDX) begin
            magic_seen_next   = {magic_seen_reg[23:0], rx_byte};
            header_count_next = header_count_reg + 4'd1;
        end else if (header_count_reg == HDR_TYPE_IDX) begin
            type_seen_next    = rx_byte;
            header_count_next = header_count_reg + 4'd1;
        end else if (header_count_reg != HDR_LAST_IDX) begin
            length_seen_next  = full_length;
            header_count_next = header_count_reg + 4'd1;
        end else begin
            // Ninth byte completes the header, which is judged now.
            result.msg_type     = type_seen_reg;
            result.frame_length = full_length;
            if (magic_seen_reg != magic_word) begin
                result.result_kind = KIND_ERROR;
                result.error_code  = ERR_BAD_MAGIC;
                clear_frame        = 1'b1;
            end else if (full_length > len_limit) begin
                result.result_kind = KIND_ERROR;
                result.error_code  = ERR_OVERSIZE;
                clear_frame        = 1'b1;
            end else if (full_length == 32'd0) begin
                result.result_kind   = KIND_HEADER;
                result.last_of_frame = 1'b1;
                clear_frame          = 1'b1;
            end else begin
                result.result_kind = KIND_HEADER;
                length_seen_next   = full_length;
                header_count_next  = '0;
                magic_seen_next    = '0;
                in_payload_next    = 1'b1;
                payload_left_next  = full_length;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_payload_reg   <= 1'b0;
            header_count_reg <= '0;
            magic_seen_reg   <= '0;
            type_seen_reg    <= '0;
            length_seen_reg  <= '0;
            payload_left_reg <= '0;
        end else if (accept) begin
            if (clear_frame) begin
                in_payload_reg   <= 1'b0;
                header_count_reg <= '0;
                magic_seen_reg   <= '0;
                type_seen_reg    <= '0;
                length_seen_reg  <= '0;
                payload_left_reg <= '0;
            end else begin
                in_payload_reg   <= in_payload_next;
                header_count_reg <= header_count_next;
                magic_seen_reg   <= magic_seen_next;
                type_seen_reg    <= type_seen_next;
                length_seen_reg  <= length_seen_next;
                payload_left_reg <= payload_left_next;
            end
        end
    end

`ifndef SYNTHESIS
    assert property (@(posedge aclk) disable iff (!aresetn)
        in_payload_reg |-> (header_count_reg == 4'd0 && payload_left_reg != 32'd0))
        else $error("payload phase with header count or zero bytes left");

    assert property (@(posedge aclk) disable iff (!aresetn)
        header_count_reg <= HDR_LAST_IDX)
        else $error("header count ran past the ninth byte");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && peer_closed) |=> (!in_payload_reg && header_count_reg == 4'd0))
        else $error("peer close did not return to header collection");
`endif

endmodule

`default_nettype wire

/* design/length_prefixed_frame_parser_top.sv */
`timescale 1ns / 1ps
`default_nettype none

// Frame deframer for a byte stream with a nine-byte header: four magic bytes,
// one type byte and a big-endian 32-bit payload length.
// Input channel (s_): one received byte, or a peer-close flag, per item.
// Result channel (m_): exactly one result item for every input item, giving
// its kind (nothing, header, payload byte, error), the frame's type and
// length, the error code and the last-of-frame mark.
// The configuration port writes the expected magic word and the largest
// accepted payload length; write it only while the block is idle.
// The result of an accepted item is registered and shows on m_valid in the next cycle.
// Throughput is one item per cycle: the single output register is refilled in
// the same cycle it is drained, so s_ready is low only while a result waits
// and m_ready is low.
// When the receiver stalls, the held result stays stable and no new item is
// taken. Reset empties the output register, returns the parser to header
// collection and loads the configuration reset values (magic 0, maximum
// length 16777216).
module length_prefixed_frame_parser_top (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         cfg_wr_en,
    input  wire         cfg_addr,
    input  wire  [31:0] cfg_wdata,
    input  wire         s_valid,
    output logic        s_ready,
    input  wire  [7:0]  s_rx_byte,
    input  wire         s_peer_closed,
    output logic        m_valid,
    input  wire         m_ready,
    output logic [1:0]  m_result_kind,
    output logic [7:0]  m_payload_byte,
    output logic [7:0]  m_msg_type,
    output logic [31:0] m_frame_length,
    output logic [1:0]  m_error_code,
    output logic        m_last_of_frame
);
    import lpfp_pkg::*;

    logic [31:0]  magic_word_reg;
    logic [31:0]  len_limit_reg;
    logic         m_valid_reg;
    lpfp_result_t res_reg;
    lpfp_result_t res_next;
    logic         accept;

    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            magic_word_reg <= '0;
            len_limit_reg  <= LEN_LIMIT_RESET;
        end else if (cfg_wr_en) begin
            if (cfg_addr == REG_MAGIC_WORD) begin
                magic_word_reg <= cfg_wdata;
            end
            if (cfg_addr == REG_LEN_LIMIT) begin
                len_limit_reg <= cfg_wdata;
            end
        end
    end

    lpfp_core u_core (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .accept      (accept),
        .rx_byte     (s_rx_byte),
        .peer_closed (s_peer_closed),
        .magic_word  (magic_word_reg),
        .len_limit   (len_limit_reg),
        .result      (res_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s_ready) begin
            m_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            res_reg <= res_next;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_result_kind   = res_reg.result_kind;
    assign m_payload_byte  = res_reg.payload_byte;
    assign m_msg_type      = res_reg.msg_type;
    assign m_frame_length  = res_reg.frame_length;
    assign m_error_code    = res_reg.error_code;
    assign m_last_of_frame = res_reg.last_of_frame;

`ifndef SYNTHESIS
    assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> m_valid_reg)
        else $error("accepted item produced no result");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && res_reg.result_kind == KIND_NONE)
            |-> (res_reg == '0))
        else $error("absorbed header byte carries nonzero fields");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> ((res_reg.error_code != ERR_NONE)
            == (res_reg.result_kind == KIND_ERROR)))
        else $error("error code does not match result kind");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && res_reg.last_of_frame)
            |-> (res_reg.result_kind == KIND_HEADER
                 || res_reg.result_kind == KIND_PAYLOAD))
        else $error("last-of-frame mark on a result that ends no frame");
`endif

endmodule

`default_nettype wire

/* sim/testbench.sv */
`timescale 1ns / 1ps

import lpfp_pkg::*;

class frame_scoreboard;
    logic [31:0]  magic_word;
    logic [31:0]  max_len;
    bit           in_payload;
    logic [3:0]   hdr_count;
    logic [31:0]  magic_acc;
    logic [7:0]   type_acc;
    logic [31:0]  len_acc;
    logic [31:0]  bytes_left;
    lpfp_result_t expected_q[$];
    int           errors;
    int           n_checked;

    function new();
        magic_word = '0;
        max_len = LEN_LIMIT_RESET;
        errors = 0;
        n_checked = 0;
        clear_frame();
    endfunction

    function void clear_frame();
        in_payload = 1'b0;
        hdr_count = '0;
        magic_acc = '0;
        type_acc = '0;
        len_acc = '0;
        bytes_left = '0;
    endfunction

    // Works out the result of one accepted byte or peer-close item.
    function void note_input(logic [7:0] rx, logic closed);
        lpfp_result_t r;
        r = '0;
        if (closed) begin
            r.result_kind = KIND_ERROR;
            r.error_code = ERR_SHORT_READ;
            if (in_payload) begin
                r.msg_type = type_acc;
                r.frame_length = len_acc;
            end
            clear_frame();
        end else if (in_payload) begin
            bytes_left = bytes_left - 32'd1;
            r.result_kind = KIND_PAYLOAD;
            r.payload_byte = rx;
            r.msg_type = type_acc;
            r.frame_length = len_acc;
            r.last_of_frame = (bytes_left == 0);
            if (bytes_left == 0) begin
                clear_frame();
            end
        end else begin
            if (hdr_count < HDR_TYPE_IDX) begin
                magic_acc = {magic_acc[23:0], rx};
            end else if (hdr_count == HDR_TYPE_IDX) begin
                type_acc = rx;
            end else begin
                len_acc = {len_acc[23:0], rx};
            end
            if (hdr_count != HDR_LAST_IDX) begin
                hdr_count = hdr_count + 4'd1;
            end else begin
                r.msg_type = type_acc;
                r.frame_length = len_acc;
                if (magic_acc != magic_word) begin
                    r.result_kind = KIND_ERROR;
                    r.error_code = ERR_BAD_MAGIC;
                    clear_frame();
                end else if (len_acc > max_len) begin
                    r.result_kind = KIND_ERROR;
                    r.error_code = ERR_OVERSIZE;
                    clear_frame();
                end else if (len_acc == 0) begin
                    r.result_kind = KIND_HEADER;
                    r.last_of_frame = 1'b1;
                    clear_frame();
                end else begin
                    r.result_kind = KIND_HEADER;
                    in_payload = 1'b1;
                    hdr_count = '0;
                    magic_acc = '0;
                    bytes_left = len_acc;
                end
            end
        end
        expected_q.push_back(r);
    endfunction

    function void compare(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
            errors++;
        end
    endfunction

    function void check_result(lpfp_result_t got);
        lpfp_result_t want;
        n_checked++;
        if (expected_q.size() == 0) begin
            $display("%0t: unexpected result expected none, got %h", $time, got);
            errors++;
            return;
        end
        want = expected_q.pop_front();
        compare("result_kind", want.result_kind, got.result_kind);
        compare("payload_byte", want.payload_byte, got.payload_byte);
        compare("msg_type", want.msg_type, got.msg_type);
        compare("frame_length", want.frame_length, got.frame_length);
        compare("error_code", want.error_code, got.error_code);
        compare("last_of_frame", want.last_of_frame, got.last_of_frame);
    endfunction
endclass

module testbench;

    localparam int PHASES      = 5;
    localparam int PHASE_ITEMS = 390;
    localparam int MAX_GAP     = 16;
    localparam int LONG_HOLD   = 300;
    localparam int LIMIT       = 400000;

    logic        aclk;
    logic        aresetn;
    logic        cfg_wr_en;
    logic        cfg_addr;
    logic [31:0] cfg_wdata;
    logic        s_valid;
    logic        s_ready;
    logic [7:0]  s_rx_byte;
    logic        s_peer_closed;
    logic        m_valid;
    logic        m_ready;
    logic [1:0]  m_result_kind;
    logic [7:0]  m_payload_byte;
    logic [7:0]  m_msg_type;
    logic [31:0] m_frame_length;
    logic [1:0]  m_error_code;
    logic        m_last_of_frame;

    frame_scoreboard sb;
    logic [7:0]      byte_q[$];
    int              n_sent;
    int              cycles;
    bit              send_calm;
    bit              recv_calm;
    bit              long_hold_done;
    lpfp_result_t    got_r;

    length_prefixed_frame_parser_top dut (.*);

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            got_r = {m_result_kind, m_payload_byte, m_msg_type, m_frame_length,
                     m_error_code, m_last_of_frame};
            sb.check_result(got_r);
        end
    end

    // Result side: random stalls, runs of none, and one long hold-off that
    // lets the output register fill and push back on the input.
    initial begin
        int gap;
        m_ready = 1'b0;
        recv_calm = 1'b0;
        long_hold_done = 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            if ($urandom_range(0, 31) == 0) begin
                recv_calm = !recv_calm;
            end
            if (!long_hold_done && sb.n_checked >= 400) begin
                gap = LONG_HOLD;
                long_hold_done = 1'b1;
            end else begin
                gap = recv_calm ? 0 : $urandom_range(0, MAX_GAP);
            end
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
    end

    task automatic send_item(input logic [7:0] rx, input logic closed);
        int gap;
        s_valid <= 1'b1;
        s_rx_byte <= rx;
        s_peer_closed <= closed;
        do @(posedge aclk); while (!s_ready);
        sb.note_input(rx, closed);
        n_sent++;
        if ($urandom_range(0, 31) == 0) begin
            send_calm = !send_calm;
        end
        gap = send_calm ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    // Sends the queued bytes; a peer close replaces the byte at close_at.
    task automatic send_bytes(input int close_at);
        for (int i = 0; i < byte_q.size(); i++) begin
            if (i == close_at) begin
                send_item(8'($urandom), 1'b1);
                break;
            end
            send_item(byte_q[i], 1'b0);
        end
        byte_q.delete();
    endtask

    task automatic push_header(input logic [31:0] mg, input logic [7:0] ty,
                               input logic [31:0] len);
        byte_q.push_back(mg[31:24]);
        byte_q.push_back(mg[23:16]);
        byte_q.push_back(mg[15:8]);
        byte_q.push_back(mg[7:0]);
        byte_q.push_back(ty);
        byte_q.push_back(len[31:24]);
        byte_q.push_back(len[23:16]);
        byte_q.push_back(len[15:8]);
        byte_q.push_back(len[7:0]);
    endtask

    task automatic random_sequence();
        int          pick;
        int          close_at;
        int          cap;
        logic [31:0] len;
        logic [31:0] flip;
        close_at = -1;
        pick = $urandom_range(0, 99);
        if (pick < 66) begin
            cap = (sb.max_len < 12) ? int'(sb.max_len) : 12;
            if (cap == 0 || $urandom_range(0, 99) < 15) begin
                len = 0;
            end else begin
                len = $urandom_range(1, cap);
            end
            push_header(sb.magic_word, 8'($urandom), len);
            for (int i = 0; i < int'(len); i++) begin
                byte_q.push_back(8'($urandom));
            end
            if ($urandom_range(0, 99) < 8) begin
                close_at = $urandom_range(0, byte_q.size() - 1);
            end
        end else if (pick < 72 && sb.max_len >= 64) begin
            len = 16 + ($urandom % (sb.max_len - 15));
            push_header(sb.magic_word, 8'($urandom), len);
            repeat (4) byte_q.push_back(8'($urandom));
            close_at = 12;
        end else if (pick < 82 && sb.max_len != 32'hFFFF_FFFF) begin
            len = sb.max_len + 1 + ($urandom % (~sb.max_len));
            push_header(sb.magic_word, 8'($urandom), len);
        end else if (pick < 90) begin
            flip = $urandom;
            if (flip == 0) begin
                flip = 32'h1 << $urandom_range(0, 31);
            end
            push_header(sb.magic_word ^ flip, 8'($urandom), $urandom);
        end else if (pick < 95) begin
            close_at = $urandom_range(0, 8);
            repeat (close_at + 1) byte_q.push_back(8'($urandom));
        end else begin
            repeat ($urandom_range(1, 12))
                send_item(8'($urandom), $urandom_range(0, 7) == 0);
            close_at = 0;
            byte_q.push_back(8'($urandom));
        end
        send_bytes(close_at);
    endtask

    task automatic wait_idle();
        s_valid <= 1'b0;
        while (sb.expected_q.size() != 0) @(posedge aclk);
        repeat (2) @(posedge aclk);
    endtask

    task automatic write_config(input logic [31:0] mg, input logic [31:0] mx);
        cfg_wr_en <= 1'b1;
        cfg_addr <= REG_MAGIC_WORD;
        cfg_wdata <= mg;
        @(posedge aclk);
        sb.magic_word = mg;
        cfg_addr <= REG_LEN_LIMIT;
        cfg_wdata <= mx;
        @(posedge aclk);
        sb.max_len = mx;
        cfg_wr_en <= 1'b0;
    endtask

    initial begin
        aresetn = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_addr = 1'b0;
        cfg_wdata = '0;
        s_valid = 1'b0;
        s_rx_byte = '0;
        s_peer_closed = 1'b0;
        n_sent = 0;
        send_calm = 1'b0;
        sb = new();
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // A two-byte frame cut short by a peer close after its first byte.
        push_header(32'h0000_0000, 8'hFF, 32'd2);
        byte_q.push_back(8'hFF);
        byte_q.push_back(8'h00);
        send_bytes(10);
        // Bad magic together with an oversize length: bad magic wins.
        push_header(32'hFFFF_FFFF, 8'h00, 32'hFFFF_FFFF);
        send_bytes(-1);
        // Peer close with nothing pending, then inside a partial header.
        send_item(8'hFF, 1'b1);
        byte_q.push_back(8'h00);
        byte_q.push_back(8'hFF);
        byte_q.push_back(8'h00);
        send_bytes(2);

        for (int phase = 0; phase < PHASES; phase++) begin
            if (phase > 0) begin
                wait_idle();
                case (phase)
                    1: write_config(32'hFFFF_FFFF, 32'd0);
                    2: write_config($urandom, 32'hFFFF_FFFF);
                    3: write_config($urandom, $urandom_range(1, 10));
                    default: write_config(32'd0, $urandom);
                endcase
            end
            while (n_sent < (phase + 1) * PHASE_ITEMS) begin
                random_sequence();
            end
        end

        wait_idle();
        repeat (4) @(posedge aclk);
        if (sb.errors == 0 && sb.expected_q.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
